// ===== rtl/assert_macros.svh =====
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cit_pkg.sv =====
package cit_pkg;

	localparam int POS_W = 12;
	localparam int KEY_W = 64;
	localparam int ROW_W = 32;
	localparam int DEF_STORE_DEPTH = 4096;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_CRACK = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]              operation;
		logic [POS_W-1:0]        entry_index;
		logic signed [KEY_W-1:0] entry_key;
		logic [ROW_W-1:0]        entry_row;
		logic [POS_W-1:0]        range_start;
		logic [POS_W-1:0]        range_end;
		logic signed [KEY_W-1:0] bound_low;
		logic signed [KEY_W-1:0] bound_high;
	} req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] read_key;
		logic [ROW_W-1:0]        read_row;
		logic [POS_W-1:0]        first_split;
		logic [POS_W-1:0]        second_split;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ROW_W-1:0] row;
	} entry_t;

	typedef enum logic [1:0] {
		AS_IDX,
		AS_TOP,
		AS_MID,
		AS_A
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_IN,
		WD_RDATA,
		WD_ENT
	} wdata_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_READ,
		RES_SPLIT
	} res_sel_t;

	typedef struct packed {
		logic       load_job;
		logic       rd_en;
		logic       wr_en;
		addr_sel_t  ra;
		addr_sel_t  wa;
		wdata_sel_t wd;
		logic       save_ent;
		logic       top_dec;
		logic       mid_from_top;
		logic       mid_dec;
		logic       a_inc;
		logic       out_load;
		res_sel_t   res;
		logic       scan;
	} cmd_t;

	typedef struct packed {
		logic top_gt_a;
		logic mid_gt_a;
		logic ge_lo;
		logic ge_hi;
	} sts_t;

endpackage

// ===== rtl/cit_dp.sv =====
`include "assert_macros.svh"

module cit_dp #(
	parameter int STORE_DEPTH = cit_pkg::DEF_STORE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cit_pkg::req_t req,
	input  cit_pkg::cmd_t cmd,
	output cit_pkg::sts_t sts,
	output cit_pkg::rsp_t rsp
);
	import cit_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int PW = ((AW > POS_W) ? AW : POS_W) + 1;

	entry_t mem [0:STORE_DEPTH-1];
	entry_t rdata_q;
	entry_t ent_q;
	entry_t wdata;

	logic [PW-1:0] a_q, top_q, mid_q;
	logic [KEY_W-1:0] lo_q, hi_q;
	logic idx_ok_q;
	rsp_t rsp_q;

	logic [PW-1:0] idx_w, end_w, end_clamp, raddr, waddr;
	logic idx_ok, rd_go, wr_go;

	function automatic logic [PW-1:0] pick_addr(addr_sel_t s, logic [PW-1:0] idx,
			logic [PW-1:0] top, logic [PW-1:0] mid, logic [PW-1:0] a);
		logic [PW-1:0] r;
		case (s)
			AS_IDX:  r = idx;
			AS_TOP:  r = top;
			AS_MID:  r = mid;
			default: r = a;
		endcase
		return r;
	endfunction

	assign idx_w = PW'(req.entry_index);
	assign end_w = PW'(req.range_end);
	assign idx_ok = idx_w < PW'(STORE_DEPTH);
	assign end_clamp = (end_w > PW'(STORE_DEPTH - 1)) ? PW'(STORE_DEPTH - 1) : end_w;

	assign raddr = pick_addr(cmd.ra, idx_w, top_q, mid_q, a_q);
	assign waddr = pick_addr(cmd.wa, idx_w, top_q, mid_q, a_q);
	// host-indexed accesses beyond the store are dropped
	assign rd_go = cmd.rd_en && (cmd.ra != AS_IDX || idx_ok);
	assign wr_go = cmd.wr_en && (cmd.wa != AS_IDX || idx_ok);

	always_comb begin
		case (cmd.wd)
			WD_IN:    wdata = '{key: req.entry_key, row: req.entry_row};
			WD_RDATA: wdata = rdata_q;
			default:  wdata = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			rdata_q <= mem[raddr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.save_ent) begin
			ent_q <= rdata_q;
		end
		if (cmd.load_job) begin
			a_q      <= PW'(req.range_start);
			top_q    <= end_clamp;
			lo_q     <= req.bound_low;
			hi_q     <= req.bound_high;
			idx_ok_q <= idx_ok;
		end else begin
			if (cmd.top_dec) begin
				top_q <= top_q - PW'(1);
			end
			if (cmd.a_inc) begin
				a_q <= a_q + PW'(1);
			end
		end
		if (cmd.mid_from_top) begin
			mid_q <= top_q;
		end else if (cmd.mid_dec) begin
			mid_q <= mid_q - PW'(1);
		end
		if (cmd.out_load) begin
			case (cmd.res)
				RES_READ: begin
					if (idx_ok_q) begin
						rsp_q <= '{read_key: rdata_q.key, read_row: rdata_q.row,
							first_split: '0, second_split: '0};
					end else begin
						rsp_q <= '0;
					end
				end
				RES_SPLIT: begin
					rsp_q <= '{read_key: '0, read_row: '0,
						first_split: mid_q[POS_W-1:0], second_split: top_q[POS_W-1:0]};
				end
				default: rsp_q <= '0;
			endcase
		end
	end

	assign sts.top_gt_a = top_q > a_q;
	assign sts.mid_gt_a = mid_q > a_q;
	assign sts.ge_lo    = $signed(rdata_q.key) >= $signed(lo_q);
	assign sts.ge_hi    = $signed(rdata_q.key) >= $signed(hi_q);
	assign rsp = rsp_q;

	// the high region never crosses the middle scan
	`ASSERT_IMPL(a_top_above_mid, clk, arst_n, cmd.scan, top_q >= mid_q, "top below mid")
	`ASSERT_NEXT(a_low_stays_below, clk, arst_n, cmd.a_inc, a_q <= mid_q, "low scan passed mid")

endmodule

// ===== rtl/cit_ctrl.sv =====
`include "assert_macros.svh"

module cit_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic [1:0]    op,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  cit_pkg::sts_t sts,
	output cit_pkg::cmd_t cmd
);
	import cit_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_HOLD    = 4'd1;
	localparam logic [3:0] S_RD_DONE = 4'd2;
	localparam logic [3:0] S_T_RD    = 4'd3;
	localparam logic [3:0] S_T_CHK   = 4'd4;
	localparam logic [3:0] S_M_RD    = 4'd5;
	localparam logic [3:0] S_M_CHK   = 4'd6;
	localparam logic [3:0] S_M_SW1   = 4'd7;
	localparam logic [3:0] S_M_SW2   = 4'd8;
	localparam logic [3:0] S_L_RD    = 4'd9;
	localparam logic [3:0] S_L_CHK   = 4'd10;
	localparam logic [3:0] S_L_SW1   = 4'd11;
	localparam logic [3:0] S_L_SW2   = 4'd12;
	localparam logic [3:0] S_DONE    = 4'd13;

	logic [3:0] state_q, state_d;
	logic out_valid_q, out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (op)
						OP_CRACK: begin
							cmd.load_job = 1'b1;
							state_d = S_T_RD;
						end
						OP_READ: begin
							cmd.load_job = 1'b1;
							cmd.rd_en = 1'b1;
							cmd.ra = AS_IDX;
							state_d = S_RD_DONE;
						end
						default: begin
							// write, or an unused code with no effect
							if (op == OP_WRITE) begin
								cmd.wr_en = 1'b1;
								cmd.wa = AS_IDX;
								cmd.wd = WD_IN;
							end
							if (out_free) begin
								cmd.out_load = 1'b1;
								cmd.res = RES_ZERO;
							end else begin
								state_d = S_HOLD;
							end
						end
					endcase
				end
			end
			S_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.res = RES_ZERO;
					state_d = S_IDLE;
				end
			end
			S_RD_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.res = RES_READ;
					state_d = S_IDLE;
				end
			end
			// skip keys already in the high region at the top
			S_T_RD: begin
				if (sts.top_gt_a) begin
					cmd.rd_en = 1'b1;
					cmd.ra = AS_TOP;
					state_d = S_T_CHK;
				end else begin
					cmd.mid_from_top = 1'b1;
					state_d = S_M_RD;
				end
			end
			S_T_CHK: begin
				if (sts.ge_hi) begin
					cmd.top_dec = 1'b1;
					state_d = S_T_RD;
				end else begin
					cmd.mid_from_top = 1'b1;
					state_d = S_M_RD;
				end
			end
			// middle scan
			S_M_RD: begin
				cmd.scan = 1'b1;
				if (sts.mid_gt_a) begin
					cmd.rd_en = 1'b1;
					cmd.ra = AS_MID;
					state_d = S_M_CHK;
				end else begin
					state_d = S_L_RD;
				end
			end
			S_M_CHK: begin
				cmd.scan = 1'b1;
				if (!sts.ge_lo) begin
					state_d = S_L_RD;
				end else if (sts.ge_hi) begin
					cmd.save_ent = 1'b1;
					cmd.rd_en = 1'b1;
					cmd.ra = AS_TOP;
					state_d = S_M_SW1;
				end else begin
					cmd.mid_dec = 1'b1;
					state_d = S_M_RD;
				end
			end
			S_M_SW1: begin
				cmd.scan = 1'b1;
				cmd.wr_en = 1'b1;
				cmd.wa = AS_MID;
				cmd.wd = WD_RDATA;
				state_d = S_M_SW2;
			end
			S_M_SW2: begin
				cmd.scan = 1'b1;
				cmd.wr_en = 1'b1;
				cmd.wa = AS_TOP;
				cmd.wd = WD_ENT;
				cmd.top_dec = 1'b1;
				cmd.mid_dec = 1'b1;
				state_d = S_M_RD;
			end
			// low-side scan
			S_L_RD: begin
				cmd.scan = 1'b1;
				if (sts.mid_gt_a) begin
					cmd.rd_en = 1'b1;
					cmd.ra = AS_A;
					state_d = S_L_CHK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_L_CHK: begin
				cmd.scan = 1'b1;
				if (!sts.ge_lo) begin
					cmd.a_inc = 1'b1;
					state_d = S_L_RD;
				end else begin
					cmd.save_ent = 1'b1;
					cmd.rd_en = 1'b1;
					cmd.ra = AS_MID;
					state_d = S_L_SW1;
				end
			end
			S_L_SW1: begin
				cmd.scan = 1'b1;
				cmd.wr_en = 1'b1;
				cmd.wa = AS_A;
				cmd.wd = WD_RDATA;
				state_d = S_L_SW2;
			end
			S_L_SW2: begin
				cmd.scan = 1'b1;
				cmd.wr_en = 1'b1;
				cmd.wa = AS_MID;
				cmd.wd = WD_ENT;
				state_d = S_M_RD;
			end
			S_DONE: begin
				cmd.scan = 1'b1;
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.res = RES_SPLIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || rsp_ready, "result overwritten")
	`ASSERT_IMPL(a_single_port, clk, arst_n, cmd.rd_en, !cmd.wr_en, "read and write in one cycle")

endmodule

// ===== rtl/crack_in_three_partition.sv =====
// Three-way in-place partition over a store of STORE_DEPTH entries (signed 64-bit key
// plus 32-bit row). Every request returns exactly one response. A write is stored
// as its request is taken; a read passes through the read data register. A crack
// walks its range through the single-port entry memory, at most one read or one
// write per cycle: each key examined is read and then compared, each swap takes two
// writes, and a swap on the low side also has its two positions examined again.
// No request is taken while a crack runs, up to the load of the response register
// and any wait for a held response. A finished response waits in an output register
// while the next request is taken. The store comes up undefined and has no clearing
// pass: read or crack only entries that have been written.
module crack_in_three_partition #(
	parameter int STORE_DEPTH = cit_pkg::DEF_STORE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cit_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cit_pkg::rsp_t rsp
);
	import cit_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.op        (req.operation),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cit_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
